FILE: hw/rtl/pwmtsp_pkg.sv
`default_nettype none

package pwmtsp_pkg;

	// tone memory
	localparam int TONE_DEPTH = 256;
	localparam int ADDR_W     = $clog2(TONE_DEPTH);

	// item fields
	localparam int KIND_W  = 2;
	localparam int INDEX_W = 8;
	localparam int FREQ_W  = 16;
	localparam int DUR_W   = 16;

	// result fields
	localparam int PER_W = 20;

	// configuration
	localparam int CLK_W      = 27;
	localparam int PSC_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 27;

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(32000000);
	localparam logic [PSC_W-1:0] PSC_RESET = PSC_W'(8);

	// timing state
	localparam int TICKS_W = 24;

	localparam logic [FREQ_W-1:0] MIN_FREQ     = FREQ_W'(100);
	localparam logic [FREQ_W-1:0] MAX_FREQ     = FREQ_W'(8000);
	localparam logic [PER_W-1:0]  PERIOD_MAX   = {PER_W{1'b1}};
	localparam logic [PER_W-1:0]  PERIOD_RESET = PER_W'(999);
	localparam logic [PER_W-1:0]  COMPARE_RESET = PER_W'(499);

	// a playable tone frequency fits in 13 bits (max 8000)
	localparam int TONE_FREQ_W = 13;
	localparam logic [TONE_FREQ_W-1:0] SILENCE_FREQ = TONE_FREQ_W'(100);

	// freq/100 as (freq * 5243) >> 19, exact for freq below 43690
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
	localparam int Q100_W      = 7;

	// period divider: core clock / (freq * prescale)
	localparam int DIVISOR_W  = TONE_FREQ_W + PSC_W;
	localparam int DIV_STEPS  = CLK_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK      = 2'd0,
		KIND_PLAY      = 2'd1,
		KIND_PLAY_PRIO = 2'd2,
		KIND_WRITE     = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CORE_CLOCK     = 2'd0,
		REG_TIMER_PRESCALE = 2'd1,
		REG_SILENT_MODE    = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_TMUL,
		S_TICKS,
		S_PMUL,
		S_DIV,
		S_PERIOD,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pwmtsp_if.sv
`default_nettype none

interface pwmtsp_req_if;
	import pwmtsp_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [INDEX_W-1:0] tone_index;
	logic [FREQ_W-1:0]  tone_freq;
	logic [DUR_W-1:0]   tone_duration;

	modport source(output valid, kind, tone_index, tone_freq, tone_duration, input ready);
	modport sink(input valid, kind, tone_index, tone_freq, tone_duration, output ready);
endinterface

interface pwmtsp_rsp_if;
	import pwmtsp_pkg::*;

	logic             valid;
	logic             ready;
	logic             output_on;
	logic [PER_W-1:0] period_value;
	logic [PER_W-1:0] compare_value;
	logic             playing;
	logic             priority_active;
	logic             accepted;

	modport source(output valid, output_on, period_value, compare_value, playing,
		priority_active, accepted, input ready);
	modport sink(input valid, output_on, period_value, compare_value, playing,
		priority_active, accepted, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pwm_tone_sequence_player_top.sv
`default_nettype none

// channel   dir  handshake      payload
// req       in   valid/ready    kind, tone_index, tone_freq, tone_duration
// rsp       out  valid/ready    output_on, period_value, compare_value, playing,
//                               priority_active, accepted
// cfg       in   wr_en only     reg_index, wr_data (no wait, no read-back)
//
// One item at a time. A tone write or a tick that does not end a tone goes from
// accept straight to the result. Starting a tone reads the tone, forms the tick
// count and runs the 27-step restoring divider for core_clock_hz/(freq*prescale).
// arst_n clears control and timer state at once; the tone memory is not cleared.
// A waiting result sits in the rsp register, so the next item is taken meanwhile;
// only the finish of that next item waits on rsp.ready.

module pwm_tone_sequence_player_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [pwmtsp_pkg::CFG_IDX_W-1:0]   reg_index,
	input  logic [pwmtsp_pkg::CFG_DATA_W-1:0]  wr_data,
	pwmtsp_req_if.sink                         req,
	pwmtsp_rsp_if.source                       rsp
);
	import pwmtsp_pkg::*;

	// sequencer
	state_t state_q, state_d;

	// configuration registers
	logic [CLK_W-1:0] clk_hz_q;
	logic [PSC_W-1:0] psc_q;
	logic             silent_q;

	// player state
	logic [ADDR_W-1:0]  entry_q;
	logic [TICKS_W-1:0] ticks_q;
	logic               list_q;
	logic               prio_q;
	logic               pwm_q;
	logic [PER_W-1:0]   period_q;
	logic [PER_W-1:0]   compare_q;

	// tone memory: {freq, duration}
	logic [FREQ_W+DUR_W-1:0] tone_mem [TONE_DEPTH];
	logic [FREQ_W+DUR_W-1:0] rd_q;

	// per-item working registers
	logic                    from_tick_q;
	logic                    acc_q;
	logic                    silence_q;
	logic [TONE_FREQ_W-1:0]  f_q;
	logic [DUR_W-1:0]        d_q;
	logic [Q100_W-1:0]       q100_q;
	logic [DIVISOR_W-1:0]    divisor_q;
	logic [DIVISOR_W-1:0]    rem_q;
	logic [CLK_W-1:0]        quo_q;
	logic [DIV_CNT_W-1:0]    cnt_q;

	// result register
	logic             rsp_valid_q;
	logic             rsp_on_q;
	logic [PER_W-1:0] rsp_period_q;
	logic [PER_W-1:0] rsp_compare_q;
	logic             rsp_playing_q;
	logic             rsp_prio_q;
	logic             rsp_acc_q;

	// control outputs of the sequencer
	logic accept;
	logic rsp_load;
	logic mem_we;

	// combinational helpers
	kind_t                      req_kind;
	logic                       play_take;
	logic [TICKS_W-1:0]         ticks_dec;
	logic [ADDR_W-1:0]          entry_next;
	logic [FREQ_W-1:0]          rd_freq;
	logic [DUR_W-1:0]           rd_dur;
	logic                       ev_end;
	logic                       ev_silence;
	logic                       ev_bad;
	logic [PSC_W-1:0]           psc_eff;
	logic [TONE_FREQ_W+RECIP_W-1:0] recip_prod;
	logic [Q100_W+DUR_W-1:0]    tick_prod;
	logic [DIVISOR_W-1:0]       div_prod;
	logic [DIVISOR_W:0]         rem_sh;
	logic                       rem_ge;
	logic [DIVISOR_W:0]         rem_diff;
	logic [CLK_W-1:0]           quo_m1;
	logic [PER_W-1:0]           per_val;

	assign req_kind = kind_t'(req.kind);
	assign accept   = req.valid && req.ready;

	// a play is refused in silent mode; a normal play also while a priority list runs
	assign play_take = !silent_q &&
		((req_kind == KIND_PLAY && !prio_q) || req_kind == KIND_PLAY_PRIO);

	assign ticks_dec  = ticks_q - TICKS_W'(1);
	assign entry_next = (entry_q == ADDR_W'(TONE_DEPTH - 1)) ? '0 : entry_q + ADDR_W'(1);

	assign rd_freq = rd_q[FREQ_W+DUR_W-1:DUR_W];
	assign rd_dur  = rd_q[DUR_W-1:0];

	// list end mark and silence only count when stepping on a tick;
	// a play that lands on them just stops the timer
	assign ev_end     = from_tick_q && rd_freq == '0 && rd_dur == '0;
	assign ev_silence = from_tick_q && rd_freq == '0 && rd_dur != '0;
	assign ev_bad     = rd_freq < MIN_FREQ || rd_freq > MAX_FREQ || rd_dur == '0;

	assign psc_eff    = (psc_q == '0) ? PSC_W'(1) : psc_q;
	assign recip_prod = f_q * RECIP_100;
	assign tick_prod  = q100_q * d_q;
	assign div_prod   = f_q * psc_eff;

	// one restoring division step
	assign rem_sh   = {rem_q, quo_q[CLK_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, divisor_q};
	assign rem_diff = rem_sh - {1'b0, divisor_q};

	// period = quotient - 1, floored at 0, saturated to 20 bits
	assign quo_m1 = quo_q - CLK_W'(1);
	always_comb begin
		if (quo_q == '0) begin
			per_val = '0;
		end else if (quo_m1 > CLK_W'(PERIOD_MAX)) begin
			per_val = PERIOD_MAX;
		end else begin
			per_val = quo_m1[PER_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_kind)
						KIND_TICK: begin
							if (pwm_q && ticks_dec == '0 && list_q) begin
								state_d = S_READ;
							end else begin
								state_d = S_DONE;
							end
						end
						KIND_PLAY, KIND_PLAY_PRIO: begin
							state_d = play_take ? S_READ : S_DONE;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_READ: state_d = S_EVAL;
			S_EVAL: begin
				if (ev_end) begin
					state_d = S_DONE;
				end else if (ev_silence) begin
					state_d = S_PMUL;
				end else if (ev_bad) begin
					state_d = S_DONE;
				end else begin
					state_d = S_TMUL;
				end
			end
			S_TMUL:   state_d = S_TICKS;
			S_TICKS:  state_d = S_PMUL;
			S_PMUL:   state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_PERIOD;
				end
			end
			S_PERIOD: state_d = S_DONE;
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = (state_q == S_IDLE);
		rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
		mem_we    = accept && req_kind == KIND_WRITE;
	end

	// control and player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clk_hz_q    <= CLK_RESET;
			psc_q       <= PSC_RESET;
			silent_q    <= 1'b0;
			entry_q     <= '0;
			ticks_q     <= '0;
			list_q      <= 1'b0;
			prio_q      <= 1'b0;
			pwm_q       <= 1'b0;
			period_q    <= PERIOD_RESET;
			compare_q   <= COMPARE_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (wr_en) begin
				case (reg_idx_t'(reg_index))
					REG_CORE_CLOCK:     clk_hz_q <= wr_data[CLK_W-1:0];
					REG_TIMER_PRESCALE: psc_q    <= wr_data[PSC_W-1:0];
					REG_SILENT_MODE:    silent_q <= wr_data[0];
					default: ;
				endcase
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_kind)
							KIND_TICK: begin
								if (pwm_q) begin
									ticks_q <= ticks_dec;
									if (ticks_dec == '0) begin
										if (!list_q) begin
											pwm_q <= 1'b0;
										end else begin
											entry_q <= entry_next;
										end
									end
								end
							end
							KIND_PLAY, KIND_PLAY_PRIO: begin
								if (play_take) begin
									entry_q <= ADDR_W'(req.tone_index);
									list_q  <= 1'b1;
									if (req_kind == KIND_PLAY_PRIO) begin
										prio_q <= 1'b1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_EVAL: begin
					if (ev_end) begin
						pwm_q  <= 1'b0;
						list_q <= 1'b0;
						prio_q <= 1'b0;
					end else if (ev_silence) begin
						ticks_q <= TICKS_W'(rd_dur) + TICKS_W'(1);
					end else if (ev_bad) begin
						pwm_q <= 1'b0;
					end
				end
				S_TICKS: begin
					ticks_q <= TICKS_W'(tick_prod) + TICKS_W'(1);
				end
				S_PERIOD: begin
					period_q  <= per_val;
					compare_q <= silence_q ? '0 : (per_val >> 1);
					pwm_q     <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// tone memory, registered read at the current entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tone_mem[ADDR_W'(req.tone_index)] <= {req.tone_freq, req.tone_duration};
		end
		rd_q <= tone_mem[entry_q];
	end

	// working registers and divider
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					from_tick_q <= (req_kind == KIND_TICK);
					acc_q       <= (req_kind == KIND_PLAY || req_kind == KIND_PLAY_PRIO)
						&& play_take;
				end
			end
			S_EVAL: begin
				silence_q <= ev_silence;
				f_q       <= ev_silence ? SILENCE_FREQ : rd_freq[TONE_FREQ_W-1:0];
				d_q       <= rd_dur;
			end
			S_TMUL: begin
				q100_q <= recip_prod[RECIP_SHIFT +: Q100_W];
			end
			S_PMUL: begin
				divisor_q <= div_prod;
				quo_q     <= clk_hz_q;
				rem_q     <= '0;
				cnt_q     <= '0;
			end
			S_DIV: begin
				rem_q <= rem_ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
				quo_q <= {quo_q[CLK_W-2:0], rem_ge};
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			default: ;
		endcase

		if (rsp_load) begin
			rsp_on_q      <= pwm_q;
			rsp_period_q  <= period_q;
			rsp_compare_q <= compare_q;
			rsp_playing_q <= list_q;
			rsp_prio_q    <= prio_q;
			rsp_acc_q     <= acc_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.output_on       = rsp_on_q;
	assign rsp.period_value    = rsp_period_q;
	assign rsp.compare_value   = rsp_compare_q;
	assign rsp.playing         = rsp_playing_q;
	assign rsp.priority_active = rsp_prio_q;
	assign rsp.accepted        = rsp_acc_q;

endmodule

`default_nettype wire
